/* sv/spq_pkg.sv */
// Shared types, constants and helpers for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH    = 32;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int TAG_BITS = 16;

  typedef enum logic [1:0] {
    K_INSERT  = 2'd0,
    K_REMOVE  = 2'd1,
    K_CHANGE  = 2'd2,
    K_EXTRACT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_DUP      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RS_ZERO = 2'd0,
    RS_OP   = 2'd1,
    RS_HIT  = 2'd2
  } res_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SCAN2,
    S_CHECK,
    S_PLACE,
    S_DONE
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] tag;
    logic [15:0] order;
    logic [15:0] priority_req;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [15:0]      out_tag;
    logic [15:0]      out_order;
    logic [15:0]      out_priority;
    logic [CNT_W-1:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [15:0]         order;
    logic [15:0]         prio;
  } entry_t;

  typedef struct packed {
    logic     load_in;
    logic     scan;
    logic     latch_hit;
    logic     drop;
    logic     load_change;
    logic     restore;
    logic     place;
    logic     out_load;
    status_t  st;
    res_sel_t rsel;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  empty;
    logic  full;
    logic  tag_found;
    logic  key_dup;
    logic  out_free;
  } dp_stat_t;

  // a sorts strictly before b
  function automatic logic ahead(entry_t a, entry_t b);
    if (a.prio != b.prio) return a.prio > b.prio;
    return a.order > b.order;
  endfunction

endpackage

/* sv/sorted_priority_queue_with_update_core.sv */
// Top level of the sorted priority queue with tag lookup and priority update.
//
//   beat    direction  handshake           payload
//   in      to core    in_valid/in_stall   in_item   (kind, tag, order, priority_req)
//   out     from core  out_valid/out_stall out_item  (status, tag, order, priority, occupancy)
//
// One item at a time: in_stall is low only in the idle state.
// Rejects, extract and remove step through scan, decide and done; insert adds a place step;
// change steps through scan, decide, scan2, check, place and done over the register row of entries.
// The done state waits until out_stall lets the result register load.
// Reset (rst, synchronous) empties the queue; entry contents are not cleared.
module sorted_priority_queue_with_update_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_item_t out_item
);
  import spq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.occupancy <= CNT_W'(DEPTH)))
    else $error("occupancy beyond depth");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status != ST_OK) |->
      (out_item.out_tag == '0 && out_item.out_order == '0 && out_item.out_priority == '0))
    else $error("payload not zero on failed operation");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while one is in work");

endmodule

/* sv/spq_datapath.sv */
// Sorted entry row, operand, match scan, shift logic and result register.
module spq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::in_item_t  in_item,
  input  spq_pkg::dp_cmd_t   cmd,
  output spq_pkg::dp_stat_t  stat,
  input  logic               out_stall,
  output logic               out_valid,
  output spq_pkg::out_item_t out_item
);
  import spq_pkg::*;

  entry_t           cells [DEPTH];
  logic [CNT_W-1:0] count;
  entry_t           op;
  kind_t            kind;
  logic [15:0]      oldp;
  entry_t           hit;
  logic [DEPTH-1:0] tagm;
  logic [DEPTH-1:0] keym;
  logic [DEPTH-1:0] tagm_next;
  logic [DEPTH-1:0] keym_next;
  logic [IDX_W-1:0] fpos;
  logic [IDX_W-1:0] selp;
  logic [IDX_W-1:0] ppos;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      tagm_next[i] = (CNT_W'(i) < count) && (cells[i].tag == op.tag);
      keym_next[i] = (CNT_W'(i) < count) && (cells[i].prio == op.prio) &&
                     (cells[i].order == op.order);
    end
  end

  // first tag match in sorted order
  always_comb begin
    fpos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (tagm[i]) fpos = IDX_W'(i);
    end
  end

  assign selp = (kind == K_EXTRACT) ? '0 : fpos;

  // ahead flags form a prefix of the held entries
  always_comb begin
    ppos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!((CNT_W'(i) < count) && ahead(cells[i], op))) ppos = IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (IDX_W'(i) >= selp) cells[i] <= cells[i+1];
      end
    end else if (cmd.place) begin
      for (int i = 1; i < DEPTH; i++) begin
        if (IDX_W'(i) > ppos) cells[i] <= cells[i-1];
      end
      cells[ppos] <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.drop) begin
      count <= count - CNT_W'(1);
    end else if (cmd.place) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind     <= in_item.kind;
      op.tag   <= in_item.tag[TAG_BITS-1:0];
      op.order <= in_item.order;
      op.prio  <= in_item.priority_req;
    end else if (cmd.load_change) begin
      op.tag   <= cells[selp].tag;
      op.order <= cells[selp].order;
      oldp     <= cells[selp].prio;
    end else if (cmd.restore) begin
      op.prio <= oldp;
    end
    if (cmd.scan) begin
      tagm <= tagm_next;
      keym <= keym_next;
    end
    if (cmd.latch_hit) hit <= cells[selp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.status    <= cmd.st;
      out_item.occupancy <= count;
      unique case (cmd.rsel)
        RS_OP: begin
          out_item.out_tag      <= 16'(op.tag);
          out_item.out_order    <= op.order;
          out_item.out_priority <= op.prio;
        end
        RS_HIT: begin
          out_item.out_tag      <= 16'(hit.tag);
          out_item.out_order    <= hit.order;
          out_item.out_priority <= hit.prio;
        end
        default: begin
          out_item.out_tag      <= '0;
          out_item.out_order    <= '0;
          out_item.out_priority <= '0;
        end
      endcase
    end
  end

  assign stat.kind      = kind;
  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CNT_W'(DEPTH));
  assign stat.tag_found = |tagm;
  assign stat.key_dup   = |keym;
  assign stat.out_free  = !out_valid || !out_stall;

endmodule

/* sv/spq_ctrl.sv */
// Operation sequencer for the sorted priority queue.
module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::dp_stat_t stat,
  output spq_pkg::dp_cmd_t  cmd
);
  import spq_pkg::*;

  state_t   state, state_next;
  status_t  st, st_next;
  res_sel_t rsel, rsel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      st    <= ST_OK;
      rsel  <= RS_ZERO;
    end else begin
      state <= state_next;
      st    <= st_next;
      rsel  <= rsel_next;
    end
  end

  always_comb begin
    state_next = state;
    st_next    = st;
    rsel_next  = rsel;
    cmd        = '0;
    cmd.st     = st;
    cmd.rsel   = rsel;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.latch_hit = 1'b1;
        state_next    = S_DONE;
        rsel_next     = RS_ZERO;
        if (stat.kind == K_INSERT) begin
          if (stat.full) begin
            st_next = ST_FULL;
          end else if (stat.key_dup) begin
            st_next = ST_DUP;
          end else begin
            st_next    = ST_OK;
            rsel_next  = RS_OP;
            state_next = S_PLACE;
          end
        end else if (stat.empty) begin
          st_next = ST_EMPTY;
        end else if (stat.kind == K_EXTRACT) begin
          cmd.drop  = 1'b1;
          st_next   = ST_OK;
          rsel_next = RS_HIT;
        end else if (!stat.tag_found) begin
          st_next = ST_NOTFOUND;
        end else if (stat.kind == K_REMOVE) begin
          cmd.drop  = 1'b1;
          st_next   = ST_OK;
          rsel_next = RS_HIT;
        end else begin
          // take the entry out, then look for a clash with its new key
          cmd.drop        = 1'b1;
          cmd.load_change = 1'b1;
          state_next      = S_SCAN2;
        end
      end
      S_SCAN2: begin
        cmd.scan   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.key_dup) begin
          cmd.restore = 1'b1;
          st_next     = ST_DUP;
          rsel_next   = RS_ZERO;
        end else begin
          st_next   = ST_OK;
          rsel_next = RS_OP;
        end
        state_next = S_PLACE;
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
